### design/x86p_pkg.sv
// shared types, codes and opcode decode functions for the 8086 predecoder
// no dependencies; used by every module of the block
`default_nettype none

package x86p_pkg;

   localparam logic [1:0] KIND_MOV = 2'd0;
   localparam logic [1:0] KIND_ADD = 2'd1;
   localparam logic [1:0] KIND_SUB = 2'd2;
   localparam logic [1:0] KIND_CMP = 2'd3;

   localparam logic [2:0] FORM_RM_REG   = 3'd0;
   localparam logic [2:0] FORM_IMM_RM   = 3'd1;
   localparam logic [2:0] FORM_IMM_REG  = 3'd2;
   localparam logic [2:0] FORM_MEM_ACC  = 3'd3;
   localparam logic [2:0] FORM_ACC_MEM  = 3'd4;
   localparam logic [2:0] FORM_IMM_ACC  = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_OPC   = 2'd1;
   localparam logic [1:0] ST_BAD_GROUP = 2'd2;

   localparam logic [2:0] SEL_ADD = 3'd0;
   localparam logic [2:0] SEL_SUB = 3'd5;
   localparam logic [2:0] SEL_CMP = 3'd7;

   localparam logic [1:0] MOD_DISP8  = 2'd1;
   localparam logic [1:0] MOD_DISP16 = 2'd2;
   localparam logic [1:0] MOD_NODISP = 2'd0;
   localparam logic [2:0] RM_DIRECT  = 3'd6;

   // opcode prefixes
   localparam logic [6:0] OPC7_MOV_IMM_RM  = 7'h63;
   localparam logic [3:0] OPC4_MOV_IMM_REG = 4'h0b;
   localparam logic [5:0] OPC6_MOV_RM_REG  = 6'h22;
   localparam logic [6:0] OPC7_MOV_MEM_ACC = 7'h50;
   localparam logic [6:0] OPC7_MOV_ACC_MEM = 7'h51;
   localparam logic [5:0] OPC6_ADD_RM_REG  = 6'h00;
   localparam logic [5:0] OPC6_GROUP_IMM   = 6'h20;
   localparam logic [6:0] OPC7_ADD_IMM_ACC = 7'h02;
   localparam logic [5:0] OPC6_SUB_RM_REG  = 6'h0a;
   localparam logic [6:0] OPC7_SUB_IMM_ACC = 7'h16;
   localparam logic [5:0] OPC6_CMP_RM_REG  = 6'h0e;
   localparam logic [6:0] OPC7_CMP_IMM_ACC = 7'h1e;

   typedef struct packed {
      logic       valid;
      logic [2:0] form;
      logic [1:0] kind;
   } class_type;

   typedef struct packed {
      logic        [1:0]  op_kind;
      logic        [2:0]  form;
      logic               is_word;
      logic               to_reg;
      logic        [1:0]  mode_bits;
      logic        [2:0]  reg_bits;
      logic        [2:0]  rm_bits;
      logic signed [15:0] displacement;
      logic        [15:0] immediate;
      logic        [2:0]  inst_length;
      logic        [1:0]  status;
   } rec_type;

   function automatic class_type classify(input logic [7:0] op);
      class_type c;
      c = '0;
      c.valid = 1'b1;
      if (op[7:1] == OPC7_MOV_IMM_RM) begin
         c.form = FORM_IMM_RM;  c.kind = KIND_MOV;
      end else if (op[7:4] == OPC4_MOV_IMM_REG) begin
         c.form = FORM_IMM_REG; c.kind = KIND_MOV;
      end else if (op[7:2] == OPC6_MOV_RM_REG) begin
         c.form = FORM_RM_REG;  c.kind = KIND_MOV;
      end else if (op[7:1] == OPC7_MOV_MEM_ACC) begin
         c.form = FORM_MEM_ACC; c.kind = KIND_MOV;
      end else if (op[7:1] == OPC7_MOV_ACC_MEM) begin
         c.form = FORM_ACC_MEM; c.kind = KIND_MOV;
      end else if (op[7:2] == OPC6_ADD_RM_REG) begin
         c.form = FORM_RM_REG;  c.kind = KIND_ADD;
      end else if (op[7:2] == OPC6_GROUP_IMM) begin
         c.form = FORM_IMM_RM;  c.kind = KIND_ADD;
      end else if (op[7:1] == OPC7_ADD_IMM_ACC) begin
         c.form = FORM_IMM_ACC; c.kind = KIND_ADD;
      end else if (op[7:2] == OPC6_SUB_RM_REG) begin
         c.form = FORM_RM_REG;  c.kind = KIND_SUB;
      end else if (op[7:1] == OPC7_SUB_IMM_ACC) begin
         c.form = FORM_IMM_ACC; c.kind = KIND_SUB;
      end else if (op[7:2] == OPC6_CMP_RM_REG) begin
         c.form = FORM_RM_REG;  c.kind = KIND_CMP;
      end else if (op[7:1] == OPC7_CMP_IMM_ACC) begin
         c.form = FORM_IMM_ACC; c.kind = KIND_CMP;
      end else begin
         c.valid = 1'b0;
      end
      return c;
   endfunction

   function automatic logic is_group(input logic [7:0] op);
      return op[7:2] == OPC6_GROUP_IMM;
   endfunction

   function automatic logic word_bit(input logic [7:0] op, input logic [2:0] form);
      return (form == FORM_IMM_REG) ? op[3] : op[0];
   endfunction

   function automatic logic [1:0] disp_len(input logic [2:0] form, input logic [7:0] modrm);
      logic [1:0] n;
      n = 2'd0;
      if (form == FORM_MEM_ACC || form == FORM_ACC_MEM) begin
         n = 2'd2;
      end else if (form == FORM_RM_REG || form == FORM_IMM_RM) begin
         if (modrm[7:6] == MOD_DISP8) begin
            n = 2'd1;
         end else if (modrm[7:6] == MOD_DISP16) begin
            n = 2'd2;
         end else if (modrm[7:6] == MOD_NODISP && modrm[2:0] == RM_DIRECT) begin
            n = 2'd2;
         end
      end
      return n;
   endfunction

   function automatic logic [1:0] imm_len(input logic [7:0] op, input logic [2:0] form);
      logic [1:0] n;
      logic       w;
      w = word_bit(op, form);
      if (form == FORM_RM_REG || form == FORM_MEM_ACC || form == FORM_ACC_MEM) begin
         n = 2'd0;
      end else if (form == FORM_IMM_RM && is_group(op)) begin
         n = (!op[1] && w) ? 2'd2 : 2'd1;
      end else begin
         n = w ? 2'd2 : 2'd1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

### design/x86p_decode.sv
// per-byte instruction tracking state and record assembly
// depends on x86p_pkg
`default_nettype none

module x86p_decode (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       byte_value,
   output logic                  rec_valid,
   output x86p_pkg::rec_type     rec
);

   logic [2:0]  pos_ff, pos_in;
   logic [2:0]  total_ff, total_in;
   logic [7:0]  opc_ff, opc_in;
   logic [7:0]  modrm_ff, modrm_in;
   logic [15:0] disp_ff, disp_in;
   logic [15:0] imm_ff, imm_in;

   x86p_pkg::class_type cls_b;
   x86p_pkg::class_type cls_h;

   assign cls_b = x86p_pkg::classify(byte_value);
   assign cls_h = x86p_pkg::classify(opc_ff);

   always_comb begin
      logic [2:0] nxt_pos;
      logic [1:0] dl;
      logic [1:0] il;
      logic [3:0] dstart;
      logic [3:0] pos4;
      logic       grp_err;
      logic       sext;
      logic [2:0] sel;
      pos_in    = pos_ff;
      total_in  = total_ff;
      opc_in    = opc_ff;
      modrm_in  = modrm_ff;
      disp_in   = disp_ff;
      imm_in    = imm_ff;
      rec_valid = 1'b0;
      rec       = '0;
      nxt_pos   = pos_ff + 3'd1;
      dl        = 2'd0;
      il        = 2'd0;
      dstart    = 4'd0;
      pos4      = {1'b0, pos_ff};
      grp_err   = 1'b0;
      sext      = 1'b0;
      sel       = 3'd0;
      if (step) begin
         if (pos_ff == 3'd0) begin
            opc_in   = byte_value;
            modrm_in = '0;
            disp_in  = '0;
            imm_in   = '0;
            if (!cls_b.valid) begin
               rec_valid       = 1'b1;
               rec.inst_length = 3'd1;
               rec.status      = x86p_pkg::ST_BAD_OPC;
            end else begin
               pos_in = 3'd1;
               if (cls_b.form <= x86p_pkg::FORM_IMM_RM) begin
                  total_in = 3'd0;
               end else begin
                  total_in = 3'd1 + {1'b0, x86p_pkg::disp_len(cls_b.form, 8'h00)}
                           + {1'b0, x86p_pkg::imm_len(byte_value, cls_b.form)};
               end
            end
         end else begin
            if (cls_h.form <= x86p_pkg::FORM_IMM_RM && pos_ff == 3'd1) begin
               modrm_in = byte_value;
               sel      = byte_value[5:3];
               if (x86p_pkg::is_group(opc_ff) && sel != x86p_pkg::SEL_ADD
                   && sel != x86p_pkg::SEL_SUB && sel != x86p_pkg::SEL_CMP) begin
                  grp_err = 1'b1;
               end else begin
                  total_in = 3'd2 + {1'b0, x86p_pkg::disp_len(cls_h.form, byte_value)}
                           + {1'b0, x86p_pkg::imm_len(opc_ff, cls_h.form)};
               end
            end else begin
               dstart = (cls_h.form <= x86p_pkg::FORM_IMM_RM) ? 4'd2 : 4'd1;
               dl     = x86p_pkg::disp_len(cls_h.form, modrm_ff);
               if (pos4 >= dstart && pos4 < dstart + {2'b00, dl}) begin
                  if (pos4 == dstart) disp_in[7:0]  = byte_value;
                  else                disp_in[15:8] = byte_value;
               end else if (pos4 >= dstart + {2'b00, dl}) begin
                  if (pos4 == dstart + {2'b00, dl}) imm_in[7:0]  = byte_value;
                  else                              imm_in[15:8] = byte_value;
               end
            end
            if (grp_err) begin
               pos_in          = 3'd0;
               total_in        = 3'd0;
               rec_valid       = 1'b1;
               rec.inst_length = 3'd2;
               rec.status      = x86p_pkg::ST_BAD_GROUP;
            end else begin
               pos_in = nxt_pos;
               if (total_in != 3'd0 && nxt_pos >= total_in) begin
                  dl   = x86p_pkg::disp_len(cls_h.form, modrm_in);
                  il   = x86p_pkg::imm_len(opc_ff, cls_h.form);
                  sext = !(x86p_pkg::is_group(opc_ff) && !opc_ff[1]);
                  rec_valid        = 1'b1;
                  rec.op_kind      = cls_h.kind;
                  rec.form         = cls_h.form;
                  rec.is_word      = x86p_pkg::word_bit(opc_ff, cls_h.form);
                  rec.displacement = disp_in;
                  rec.immediate    = imm_in;
                  rec.inst_length  = total_in;
                  rec.status       = x86p_pkg::ST_OK;
                  if (dl == 2'd1) begin
                     rec.displacement = {{8{disp_in[7]}}, disp_in[7:0]};
                  end
                  if (il == 2'd1) begin
                     rec.immediate = {(sext && imm_in[7]) ? 8'hff : 8'h00, imm_in[7:0]};
                  end
                  if (cls_h.form == x86p_pkg::FORM_IMM_RM && x86p_pkg::is_group(opc_ff)) begin
                     unique case (modrm_in[5:3])
                        x86p_pkg::SEL_ADD: rec.op_kind = x86p_pkg::KIND_ADD;
                        x86p_pkg::SEL_SUB: rec.op_kind = x86p_pkg::KIND_SUB;
                        default:           rec.op_kind = x86p_pkg::KIND_CMP;
                     endcase
                  end
                  if (cls_h.form <= x86p_pkg::FORM_IMM_RM) begin
                     rec.mode_bits = modrm_in[7:6];
                     rec.rm_bits   = modrm_in[2:0];
                  end
                  if (cls_h.form == x86p_pkg::FORM_RM_REG) begin
                     rec.reg_bits = modrm_in[5:3];
                     rec.to_reg   = opc_ff[1];
                  end
                  if (cls_h.form == x86p_pkg::FORM_IMM_REG) begin
                     rec.reg_bits = opc_ff[2:0];
                  end
                  pos_in   = 3'd0;
                  total_in = 3'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         total_ff <= '0;
         opc_ff   <= '0;
         modrm_ff <= '0;
         disp_ff  <= '0;
         imm_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         total_ff <= total_in;
         opc_ff   <= opc_in;
         modrm_ff <= modrm_in;
         disp_ff  <= disp_in;
         imm_ff   <= imm_in;
      end
   end

endmodule

`default_nettype wire

### design/x86p_out_reg.sv
// result register holding one decoded record until the receiver takes it
// depends on x86p_pkg
`default_nettype none

module x86p_out_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire x86p_pkg::rec_type rec,
   input  wire logic             take,
   output logic                  valid,
   output x86p_pkg::rec_type     data
);

   logic              valid_ff, valid_in;
   x86p_pkg::rec_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = rec;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

`default_nettype wire

### design/x86_16_instruction_predecoder_top.sv
// top level of the 8086 mov/add/sub/cmp predecoder: input byte register,
// decoder state and result register; depends on x86p_pkg, x86p_decode, x86p_out_reg
//
// usage
//   req channel: one code byte per word on req_tdata, in stream order
//   rsp channel: one decoded record per completed instruction, unknown
//     opcode or bad 80-83 group selector; bytes that do not finish an
//     instruction give no word
//   path: the byte that completes an instruction is held in the input byte
//     register, passes the decode pass and its record is registered on rsp
//   throughput: one byte per cycle unless stalled, set by the single decode
//     pass between the input byte register and the result register
//   reset: synchronous, clears the decode state so the next byte is taken
//     as an opcode, and empties both registers
//   stall: while a record waits in the result register and rsp_tready is
//     low, the input register holds its byte and req_tready drops once it
//     is full; nothing is lost or repeated
`default_nettype none

module x86_16_instruction_predecoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // byte_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata    // op_kind, form, is_word, to_reg, mode_bits,
                                         // reg_bits, rm_bits, displacement, immediate,
                                         // inst_length, status, zero pad
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff, in_byte_in;
   logic              out_free;
   logic              go;
   logic              rec_valid;
   x86p_pkg::rec_type rec;
   x86p_pkg::rec_type out_rec;

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign go         = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   x86p_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (go),
      .byte_value (in_byte_ff),
      .rec_valid  (rec_valid),
      .rec        (rec)
   );

   x86p_out_reg u_out_reg (
      .clock (clock),
      .reset (reset),
      .load  (go && rec_valid),
      .rec   (rec),
      .take  (rsp_tready),
      .valid (rsp_tvalid),
      .data  (out_rec)
   );

   assign rsp_tdata = {4'b0000,
                       out_rec.status,
                       out_rec.inst_length,
                       out_rec.immediate,
                       out_rec.displacement,
                       out_rec.rm_bits,
                       out_rec.reg_bits,
                       out_rec.mode_bits,
                       out_rec.to_reg,
                       out_rec.is_word,
                       out_rec.form,
                       out_rec.op_kind};

endmodule

`default_nettype wire
